>>> src/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types and constants of the message ring deque: field widths, action
// codes, stream packing and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mrd_pkg;

    localparam int ACT_W      = 2;
    localparam int MSG_W      = 32;
    localparam int FILL_W     = 5;
    localparam int CAP_W      = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_JAM   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RECV  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    // s_tdata: action, message_in
    localparam int S_ACT_LSB  = 0;
    localparam int S_MSG_LSB  = S_ACT_LSB + ACT_W;
    // m_tdata: ok, message_out, fill_count
    localparam int M_OK_BIT   = 0;
    localparam int M_MSG_LSB  = M_OK_BIT + 1;
    localparam int M_FILL_LSB = M_MSG_LSB + MSG_W;
    localparam int M_USED_W   = M_FILL_LSB + FILL_W;

    typedef struct packed {
        logic load;
        logic norm;
        logic exec;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic head_over;
        logic out_free;
    } sts_t;

endpackage

>>> src/message_ring_deque.sv
// ----------------------------------------------------------------------------
// message_ring_deque
// Sequence: the controller takes a request, brings the head below a lowered
// capacity by one capacity subtraction per normalise step, executes the action
// around the single slot memory port, then loads the result once the output
// register is free. No new request is taken until the last one is answered.
// Reset: synchronous, active low; empties the queue, capacity back to 16.
// ----------------------------------------------------------------------------
module message_ring_deque #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mrd_pkg::S_TDATA_W-1:0]  s_tdata,   // action, message_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mrd_pkg::M_TDATA_W-1:0]  m_tdata,   // ok, message_out, fill_count
    input  logic                           cfg_wr_en,
    input  logic [mrd_pkg::CAP_W-1:0]      cfg_wr_data
);
    import mrd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_refused_no_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_OK_BIT]) |-> (m_tdata[M_MSG_LSB +: MSG_W] == '0))
        else $error("refused request carries a message");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[M_FILL_LSB +: FILL_W]) <= DEPTH))
        else $error("fill count above slot depth");

    a_respond_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.respond |=> !cmd.respond)
        else $error("result loaded twice for one request");

endmodule

>>> src/mrd_ctrl.sv
// ----------------------------------------------------------------------------
// mrd_ctrl
// Sequencer of the message ring deque: takes a request, normalises the head
// against the capacity, executes the action, then hands over the result.
// ----------------------------------------------------------------------------
module mrd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mrd_pkg::sts_t sts,
    output mrd_pkg::cmd_t cmd
);
    import mrd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.head_over) begin
                    cmd.norm = 1'b1;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/mrd_dpath.sv
// ----------------------------------------------------------------------------
// mrd_dpath
// Datapath of the message ring deque: slot memory, head and fill counters,
// capacity register, request capture and the output register.
// ----------------------------------------------------------------------------
module mrd_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mrd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mrd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [mrd_pkg::CAP_W-1:0]      cfg_wr_data,
    input  mrd_pkg::cmd_t                  cmd,
    output mrd_pkg::sts_t                  sts
);
    import mrd_pkg::*;

    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [MSG_W-1:0]     mem [DEPTH];

    logic [CAP_W-1:0]     cap_reg;
    logic [HW-1:0]        head_reg;
    logic [HW-1:0]        head_next;
    logic [HW-1:0]        hnorm_reg;
    logic [CW-1:0]        held_reg;
    logic [CW-1:0]        held_next;
    logic [ACT_W-1:0]     action_reg;
    logic [MSG_W-1:0]     msg_reg;
    logic [MSG_W-1:0]     rd_data_reg;
    logic                 ok_reg;
    logic                 ok_next;
    logic                 rx_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [CW-1:0]        cap_eff;
    logic [CW:0]          tail_sum;
    logic [HW-1:0]        tail;
    logic [HW-1:0]        addr;
    logic                 we;
    logic                 has_room;
    logic [MSG_W-1:0]     msg_out;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (int'(cap_reg) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign sts.head_over = (CW+1)'(hnorm_reg) >= (CW+1)'(cap_eff);
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign has_room = held_reg < cap_eff;
    assign tail_sum = (CW+1)'(hnorm_reg) + (CW+1)'(held_reg);
    assign tail     = (tail_sum >= (CW+1)'(cap_eff)) ? HW'(tail_sum - (CW+1)'(cap_eff))
                                                     : HW'(tail_sum);

    always_comb begin
        head_next = head_reg;
        held_next = held_reg;
        ok_next   = 1'b0;
        addr      = hnorm_reg;
        we        = 1'b0;
        case (action_reg)
            ACT_SEND: begin
                if (has_room) begin
                    addr      = tail;
                    we        = 1'b1;
                    head_next = hnorm_reg;
                    held_next = held_reg + CW'(1);
                    ok_next   = 1'b1;
                end
            end
            ACT_JAM: begin
                if (has_room) begin
                    addr      = (hnorm_reg == '0) ? HW'(cap_eff - CW'(1))
                                                  : hnorm_reg - HW'(1);
                    we        = 1'b1;
                    head_next = addr;
                    held_next = held_reg + CW'(1);
                    ok_next   = 1'b1;
                end
            end
            ACT_RECV: begin
                if (held_reg != '0) begin
                    head_next = ((CW+1)'(hnorm_reg) + (CW+1)'(1) == (CW+1)'(cap_eff))
                                ? '0 : hnorm_reg + HW'(1);
                    held_next = held_reg - CW'(1);
                    ok_next   = 1'b1;
                end
            end
            default: begin
                head_next = '0;
                held_next = '0;
                ok_next   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && we) begin
            mem[addr] <= msg_reg;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_tdata[S_ACT_LSB +: ACT_W];
            msg_reg    <= s_tdata[S_MSG_LSB +: MSG_W];
            hnorm_reg  <= head_reg;
        end else if (cmd.norm) begin
            hnorm_reg  <= HW'((CW+1)'(hnorm_reg) - (CW+1)'(cap_eff));
        end
        if (cmd.exec) begin
            ok_reg <= ok_next;
            rx_reg <= ok_next && (action_reg == ACT_RECV);
        end
        if (cmd.respond) begin
            m_data_reg <= {(M_TDATA_W-M_USED_W)'(0), FILL_W'(held_reg), msg_out, ok_reg};
        end
    end

    assign msg_out = rx_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            head_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                head_reg <= head_next;
                held_reg <= held_next;
            end
            if (cmd.respond) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> dv/tb_message_ring_deque.sv
// ----------------------------------------------------------------------------
// tb_message_ring_deque
// Stream-level check of the message ring deque. An initial block builds
// requests phase by phase, predicts each result as it goes and queues both.
// A clocked driver presents the requests and a clocked monitor takes the
// results, each with random idle gaps that some phases switch off. The
// monitor compares every result field by field with the oldest prediction.
// Capacity is rewritten between phases, once all results are in, so the
// queue sometimes holds messages across a change.
// ----------------------------------------------------------------------------
module tb_message_ring_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1450;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic             ok;
        logic [MSG_W-1:0] word;
        logic [FILL_W-1:0] fill;
    } deque_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]      cfg_wr_data = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [S_TDATA_W-1:0]  pending_requests [$];
    deque_result_t         awaited_results [$];

    logic [MSG_W-1:0]      ring_slot    [SLOTS];
    bit                    ring_written [SLOTS];
    int                    ring_head    = 0;
    int                    ring_held    = 0;
    logic [CAP_W-1:0]      ring_cap     = CAP_RESET;

    int                    issued     = 0;
    int                    mismatches = 0;
    int                    cycles     = 0;
    int                    tx_gap     = 0;
    int                    rx_stall   = 0;
    bit                    tx_idle_on = 1'b1;
    bit                    rx_idle_on = 1'b1;
    deque_result_t         want;
    deque_result_t         seen;

    message_ring_deque #(
        .DEPTH(SLOTS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // action, message_in
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // ok, message_out, fill_count
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // predict one request and queue it with its expected result
    task automatic queue_request(input logic [ACT_W-1:0] act_in, input logic [MSG_W-1:0] word);
        logic [ACT_W-1:0]     act;
        int                   cap;
        int                   h;
        int                   tail;
        deque_result_t        res;
        logic [S_TDATA_W-1:0] req;
        act = act_in;
        cap = (ring_cap == 0) ? 1 : ((ring_cap > SLOTS) ? SLOTS : int'(ring_cap));
        h   = ring_head % cap;
        // never pop a slot that was never written
        if (act == ACT_RECV && ring_held != 0 && !ring_written[h]) act = ACT_CLEAR;
        res = '0;
        case (act)
            ACT_SEND: begin
                if (ring_held < cap) begin
                    tail = (h + ring_held) % cap;
                    ring_slot[tail]    = word;
                    ring_written[tail] = 1'b1;
                    ring_held++;
                    ring_head = h;
                    res.ok    = 1'b1;
                end
            end
            ACT_JAM: begin
                if (ring_held < cap) begin
                    h = (h + cap - 1) % cap;
                    ring_slot[h]    = word;
                    ring_written[h] = 1'b1;
                    ring_held++;
                    ring_head = h;
                    res.ok    = 1'b1;
                end
            end
            ACT_RECV: begin
                if (ring_held != 0) begin
                    res.word  = ring_slot[h];
                    ring_head = (h + 1) % cap;
                    ring_held--;
                    res.ok    = 1'b1;
                end
            end
            default: begin
                ring_head = 0;
                ring_held = 0;
                res.ok    = 1'b1;
            end
        endcase
        res.fill = ring_held[FILL_W-1:0];
        req = '0;
        req[S_ACT_LSB +: ACT_W] = act;
        req[S_MSG_LSB +: MSG_W] = word;
        pending_requests.insert(pending_requests.size(), req);
        awaited_results.insert(awaited_results.size(), res);
        issued++;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ring_cap = value;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_tdata  <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
                tx_gap   <= tx_idle_on ? idle_length() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.ok   = m_tdata[M_OK_BIT];
                seen.word = m_tdata[M_MSG_LSB +: MSG_W];
                seen.fill = m_tdata[M_FILL_LSB +: FILL_W];
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: ok %0d message_out %h fill_count %0d",
                           seen.ok, seen.word, seen.fill);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.ok !== want.ok) begin
                        $error("ok: expected %0d actual %0d", want.ok, seen.ok);
                        mismatches++;
                    end
                    if (seen.word !== want.word) begin
                        $error("message_out: expected %h actual %h", want.word, seen.word);
                        mismatches++;
                    end
                    if (seen.fill !== want.fill) begin
                        $error("fill_count: expected %0d actual %0d", want.fill, seen.fill);
                        mismatches++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall <= idle_length() + 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [CAP_W-1:0] cap_plan [8];
        logic [ACT_W-1:0] act;
        logic [MSG_W-1:0] word;
        int               phase;
        int               len;
        int               bias;
        int               r;
        int               m;
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd4, 5'd16, 5'd2};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty refusal, extremes, jam wrapping below slot zero, clear
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_SEND, 32'h0000_0000);
        queue_request(ACT_SEND, 32'hFFFF_FFFF);
        queue_request(ACT_JAM,  32'hA5A5_A5A5);
        queue_request(ACT_JAM,  32'h5A5A_5A5A);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_SEND, 32'h0000_0001);
        queue_request(ACT_CLEAR, 32'hFFFF_FFFF);
        queue_request(ACT_RECV, 32'h0000_0000);
        // full refusal on a small ring
        write_capacity(5'd2);
        queue_request(ACT_SEND, 32'h1234_5678);
        queue_request(ACT_JAM,  32'h8765_4321);
        queue_request(ACT_SEND, 32'hDEAD_DEAD);
        queue_request(ACT_JAM,  32'hBEEF_BEEF);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_RECV, 32'h0000_0000);
        // zero capacity acts as one slot
        write_capacity(5'd0);
        queue_request(ACT_SEND, 32'hAAAA_AAAA);
        queue_request(ACT_SEND, 32'h5555_5555);
        queue_request(ACT_RECV, 32'h0000_0000);
        queue_request(ACT_JAM,  32'hCAFE_F00D);
        queue_request(ACT_CLEAR, 32'h0000_0000);

        phase = 0;
        while (issued < ITEM_TARGET) begin
            if (phase < 8) write_capacity(cap_plan[phase]);
            else if ($urandom_range(0, 3) == 0) write_capacity(5'($urandom_range(0, 31)));
            else write_capacity(5'($urandom_range(1, 6)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            bias = $urandom_range(0, 2);
            len  = $urandom_range(40, 160);
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (bias)
                    0: act = (r < 30) ? ACT_SEND : (r < 50) ? ACT_JAM :
                             (r < 95) ? ACT_RECV : ACT_CLEAR;
                    1: act = (r < 45) ? ACT_SEND : (r < 70) ? ACT_JAM :
                             (r < 95) ? ACT_RECV : ACT_CLEAR;
                    default: act = (r < 20) ? ACT_SEND : (r < 30) ? ACT_JAM :
                                   (r < 97) ? ACT_RECV : ACT_CLEAR;
                endcase
                m = $urandom_range(0, 15);
                word = (m == 0) ? 32'h0000_0000 : (m == 1) ? 32'hFFFF_FFFF : $urandom();
                queue_request(act, word);
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/mrd_pkg.sv
src/mrd_ctrl.sv
src/mrd_dpath.sv
src/message_ring_deque.sv
dv/tb_message_ring_deque.sv
